### design/mvpi_pkg.sv
// Package for the multi-vehicle pose integrator: types, constants, CORDIC table.
// No dependencies; used by the interfaces and every module.
package mvpi_pkg;

    localparam logic [15:0] STEP_PERIOD_RESET = 16'd3277;
    localparam logic [31:0] RAD_TO_BAM_Q16    = 32'd683565276;
    localparam logic [31:0] INV_GAIN_Q32      = 32'd2608131496;
    localparam int          ATAN_ENTRIES      = 24;

    localparam logic MODE_VEL = 1'b0;
    localparam logic MODE_SET = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [3:0]        vehicle_index;
        logic signed [15:0] linear_speed;
        logic signed [15:0] angular_rate;
        logic signed [31:0] set_x;
        logic signed [31:0] set_y;
        logic [15:0]       set_heading;
    } t_cmd;

    typedef struct packed {
        logic [3:0]         out_vehicle;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading;
    } t_pose;

    // queued work for the back end
    typedef struct packed {
        logic               mode;
        logic               in_range;
        logic [3:0]         vehicle;
        logic signed [31:0] travel; // v * t, Q8.24
        logic signed [31:0] turn;   // w * t, Q8.24
        logic signed [31:0] set_x;
        logic signed [31:0] set_y;
        logic [15:0]        set_heading;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SCALE, S_CORDIC, S_WRITE, S_OUT
    } t_state;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

### design/mvpi_cmd_if.sv
// Valid/ready channel carrying one command item.
// Depends on mvpi_pkg.
interface mvpi_cmd_if;
    logic             valid;
    logic             ready;
    mvpi_pkg::t_cmd   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/mvpi_pose_if.sv
// Valid/ready channel carrying one pose result item.
// Depends on mvpi_pkg.
interface mvpi_pose_if;
    logic             valid;
    logic             ready;
    mvpi_pkg::t_pose  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/mvpi_front.sv
// Front end: accepts commands, checks the vehicle index, forms v*t and w*t
// and pushes a job into a two-entry queue. Depends on mvpi_pkg.
module mvpi_front #(
    parameter int NUM_VEHICLES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_step_period,
    mvpi_cmd_if.sink          cmd,
    input  logic              i_pop,
    output logic              o_job_valid,
    output mvpi_pkg::t_job    o_job
);
    import mvpi_pkg::*;

    t_job       r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    t_job       n_job;
    logic       push;

    assign cmd.ready   = (r_cnt != 2'd2);
    assign push        = cmd.valid && cmd.ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rd];

    always_comb begin
        n_job.mode        = cmd.data.mode;
        n_job.in_range    = ({28'd0, cmd.data.vehicle_index} < 32'(NUM_VEHICLES));
        n_job.vehicle     = cmd.data.vehicle_index;
        n_job.travel      = cmd.data.linear_speed * $signed({1'b0, i_step_period});
        n_job.turn        = cmd.data.angular_rate * $signed({1'b0, i_step_period});
        n_job.set_x       = cmd.data.set_x;
        n_job.set_y       = cmd.data.set_y;
        n_job.set_heading = cmd.data.set_heading;
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= n_job;
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (i_pop && o_job_valid) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop && o_job_valid);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !push) else $error("push into full queue");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_job_valid) else $error("pop from empty queue");
endmodule

### design/mvpi_back.sv
// Back end: pose store, heading update, distance scaling, iterative CORDIC,
// saturating position update and output register. Depends on mvpi_pkg.
module mvpi_back #(
    parameter int NUM_VEHICLES = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  mvpi_pkg::t_job    i_job,
    output logic              o_pop,
    mvpi_pose_if.source       res
);
    import mvpi_pkg::*;

    localparam int VW    = (NUM_VEHICLES > 1) ? $clog2(NUM_VEHICLES) : 1;
    localparam int NSTEP = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

    logic [31:0] r_xs [NUM_VEHICLES];
    logic [31:0] r_ys [NUM_VEHICLES];
    logic [15:0] r_hs [NUM_VEHICLES];
    logic [NUM_VEHICLES-1:0] r_vld;

    t_state r_state, n_state;
    t_job   r_job;
    logic [VW-1:0] idx;
    logic signed [63:0] r_prod;
    logic [15:0] r_h;
    logic signed [39:0] r_x, r_y;
    logic signed [32:0] r_z;
    logic [4:0] r_i;
    logic signed [31:0] cur_x, cur_y;
    logic [15:0] cur_h;
    logic signed [39:0] xs, ys, xr, yr;
    logic signed [31:0] xq, yq, sx, sy;
    logic signed [32:0] sumx, sumy;
    logic [15:0] dh, h_new;
    logic signed [63:0] xsc;
    logic r_ov;
    t_pose r_res;

    assign idx   = r_job.vehicle[VW-1:0];
    assign cur_x = r_vld[idx] ? $signed(r_xs[idx]) : 32'sd0;
    assign cur_y = r_vld[idx] ? $signed(r_ys[idx]) : 32'sd0;
    assign cur_h = r_vld[idx] ? r_hs[idx] : 16'd0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_job_valid) n_state = S_MUL;
            S_MUL:    n_state = (!r_job.in_range || r_job.mode == MODE_SET) ? S_WRITE
                                : S_SCALE;
            S_SCALE:  n_state = S_CORDIC;
            S_CORDIC: if (r_i == 5'(NSTEP - 1)) n_state = S_WRITE;
            S_WRITE:  n_state = S_OUT;
            S_OUT:    if (res.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = (r_state == S_IDLE) && i_job_valid;
        res.valid = (r_state == S_OUT);
        res.data  = r_res;
    end

    // heading step rounded into binary-angle units
    assign dh    = 16'((r_prod + 64'sd549755813888) >>> 40);
    assign h_new = cur_h + dh;
    assign xsc   = r_prod + 64'sd2147483648;

    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;
    assign xr = (r_x + 40'sd128) >>> 8;
    assign yr = (r_y + 40'sd128) >>> 8;
    assign xq = 32'(xr);
    assign yq = 32'(yr);
    assign sumx = 33'(cur_x) + 33'(xq);
    assign sumy = 33'(cur_y) + 33'(yq);
    assign sx = (sumx[32] != sumx[31]) ? {sumx[32], {31{~sumx[32]}}} : sumx[31:0];
    assign sy = (sumy[32] != sumy[31]) ? {sumy[32], {31{~sumy[32]}}} : sumy[31:0];

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (i_job_valid) begin
                r_job  <= i_job;
                r_prod <= 64'(i_job.turn) * $signed({1'b0, RAD_TO_BAM_Q16});
            end
            S_MUL: begin
                r_h    <= h_new;
                r_prod <= 64'(r_job.travel) * $signed({1'b0, INV_GAIN_Q32});
            end
            S_SCALE: begin
                r_i <= 5'd0;
                r_y <= 40'sd0;
                // fold the left half plane onto the right, z as signed 33-bit angle
                if (r_h[15] != r_h[14]) begin
                    r_x <= -40'(xsc >>> 32);
                    r_z <= $signed({~r_h[15], ~r_h[15], r_h[14:0], 16'd0});
                end else begin
                    r_x <= 40'(xsc >>> 32);
                    r_z <= $signed({r_h[15], r_h, 16'd0});
                end
            end
            S_CORDIC: begin
                r_i <= r_i + 5'd1;
                if (!r_z[32]) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - $signed({1'b0, atan_lut(r_i)});
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + $signed({1'b0, atan_lut(r_i)});
                end
            end
            S_WRITE: begin
                r_res.out_vehicle <= r_job.vehicle;
                if (!r_job.in_range) begin
                    r_res.pos_x <= '0; r_res.pos_y <= '0; r_res.heading <= '0;
                end else if (r_job.mode == MODE_SET) begin
                    r_xs[idx] <= r_job.set_x;
                    r_ys[idx] <= r_job.set_y;
                    r_hs[idx] <= r_job.set_heading;
                    r_res.pos_x <= r_job.set_x;
                    r_res.pos_y <= r_job.set_y;
                    r_res.heading <= r_job.set_heading;
                end else begin
                    r_xs[idx] <= sx;
                    r_ys[idx] <= sy;
                    r_hs[idx] <= r_h;
                    r_res.pos_x <= sx;
                    r_res.pos_y <= sy;
                    r_res.heading <= r_h;
                end
            end
            default: ;
        endcase
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= 1'b0;
            if (r_state == S_WRITE && r_job.in_range) r_vld[idx] <= 1'b1;
        end
    end

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_MUL)) else $error("job not started");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.valid && !res.ready) |=> (res.valid && $stable(r_res)))
        else $error("result changed while stalled");
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORDIC) |-> (r_i < 5'(NSTEP))) else $error("cordic overrun");
    a_no_ovf_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n) !r_ov)
        else $error("internal flag set");
endmodule

### design/multi_vehicle_pose_integrator.sv
// Multi-vehicle planar pose integrator (dead reckoning), top level.
// Channels: cmd (valid/ready, t_cmd) in; pose (valid/ready, t_pose) out.
// Config: i_step_period_we / i_step_period_wd write step period (Q0.16 s),
// taken at any edge with the enable high; write only while idle.
// A command enters a two-entry queue in the front end, which forms v*t and
// w*t. The back end takes one job at a time: heading product, distance
// scaling, min(CORDIC_STEPS, 24) CORDIC iterations, store write, then holds
// the pose in its output register until taken. The iteration count of the
// shared CORDIC stage sets the rate of velocity items; set-pose or
// out-of-range items skip the distance scaling and CORDIC steps.
// The front keeps accepting while the back is busy or the output stalls,
// until its queue holds two items. An out-of-range vehicle index returns a
// zero pose and changes nothing.
// Reset (synchronous, active low) empties the queue, sets the step period
// to 0.05 s and marks every pose zero through per-vehicle valid bits.
module multi_vehicle_pose_integrator #(
    parameter int NUM_VEHICLES = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step_period_we,
    input  logic [15:0] i_step_period_wd,
    mvpi_cmd_if.sink    cmd,
    mvpi_pose_if.source pose
);
    import mvpi_pkg::*;

    logic [15:0] r_step_period;
    logic        job_valid, pop;
    t_job        job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_step_period <= STEP_PERIOD_RESET;
        else if (i_step_period_we) r_step_period <= i_step_period_wd;
    end

    mvpi_front #(.NUM_VEHICLES(NUM_VEHICLES)) u_front (
        .i_clk, .i_rst_n, .i_step_period(r_step_period), .cmd,
        .i_pop(pop), .o_job_valid(job_valid), .o_job(job)
    );

    mvpi_back #(.NUM_VEHICLES(NUM_VEHICLES), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk, .i_rst_n, .i_job_valid(job_valid), .i_job(job),
        .o_pop(pop), .res(pose)
    );
endmodule

### dv/multi_vehicle_pose_integrator_tb.sv
// Testbench for multi_vehicle_pose_integrator: drives pose commands, predicts poses
// with a bit-exact dead-reckoning model and checks every returned pose in order.
// Depends on mvpi_pkg, mvpi_cmd_if, mvpi_pose_if and the design top level.
`timescale 1ns / 100ps

module multi_vehicle_pose_integrator_tb;
    import mvpi_pkg::*;

    localparam int NVEH  = 16;
    localparam int NSTEP = 16;
    localparam int DRAIN = 64;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_step_period_we = 1'b0;
    logic [15:0] i_step_period_wd = '0;

    mvpi_cmd_if  cmd_ch ();
    mvpi_pose_if pose_ch ();

    multi_vehicle_pose_integrator #(.NUM_VEHICLES(NVEH), .CORDIC_STEPS(NSTEP)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_step_period_we(i_step_period_we), .i_step_period_wd(i_step_period_wd),
        .cmd(cmd_ch.sink), .pose(pose_ch.source)
    );

    always #1 i_clk = ~i_clk;

    // model state
    logic [15:0] mdl_period;
    logic [31:0] mdl_x [NVEH];
    logic [31:0] mdl_y [NVEH];
    logic [15:0] mdl_hdg [NVEH];

    t_pose pending_poses[$];
    int    error_count = 0;
    bit    idle_on = 1'b1;

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        pose_ch.ready = 1'b0;
    end

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] sat_add(logic [31:0] p, longint d);
        longint r;
        r = longint'($signed(p)) + d;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic t_pose integrate_pose(t_cmd c);
        t_pose  r;
        longint v, w, t, p, d, x, y, z, xs, ys;
        logic [63:0] pu;
        logic [15:0] dh, h;
        logic [31:0] za;
        int idx;
        r = '0;
        r.out_vehicle = c.vehicle_index;
        idx = c.vehicle_index;
        if (idx >= NVEH) return r;
        if (c.mode == MODE_SET) begin
            mdl_x[idx] = c.set_x;
            mdl_y[idx] = c.set_y;
            mdl_hdg[idx] = c.set_heading;
        end else begin
            v = c.linear_speed;
            w = c.angular_rate;
            t = {48'd0, mdl_period};
            p = w * t * longint'(RAD_TO_BAM_Q16);
            pu = p + (64'd1 << 39);
            dh = pu[55:40];
            h = mdl_hdg[idx] + dh;
            d = v * t;
            x = floor_sh(d * longint'(INV_GAIN_Q32) + (64'sd1 <<< 31), 32);
            y = 0;
            za = {h, 16'd0};
            if (za >= 32'h4000_0000 && za < 32'hC000_0000) begin
                x = -x;
                za = za - 32'h8000_0000;
            end
            z = longint'($signed(za));
            for (int i = 0; i < NSTEP && i < ATAN_ENTRIES; i++) begin
                xs = floor_sh(x, i);
                ys = floor_sh(y, i);
                if (z >= 0) begin
                    x -= ys; y += xs; z -= longint'(atan_lut(5'(i)));
                end else begin
                    x += ys; y -= xs; z += longint'(atan_lut(5'(i)));
                end
            end
            mdl_x[idx] = sat_add(mdl_x[idx], floor_sh(x + 128, 8));
            mdl_y[idx] = sat_add(mdl_y[idx], floor_sh(y + 128, 8));
            mdl_hdg[idx] = h;
        end
        r.pos_x = mdl_x[idx];
        r.pos_y = mdl_y[idx];
        r.heading = mdl_hdg[idx];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    // sender: drive one command and wait for its transfer; valid stays high
    // only while a fresh command follows in the same step
    task automatic send_cmd(t_cmd c);
        t_pose exp_pose;
        while (idle_on && $urandom_range(99) < 19) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data <= c;
        do @(posedge i_clk); while (!cmd_ch.ready);
        exp_pose = integrate_pose(c);
        pending_poses = {pending_poses, exp_pose};
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (pending_poses.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_period(logic [15:0] val);
        wait_drained();
        i_step_period_we <= 1'b1;
        i_step_period_wd <= val;
        @(posedge i_clk);
        i_step_period_we <= 1'b0;
        mdl_period = val;
    endtask

    function automatic t_cmd vel_cmd(int veh, logic [15:0] v, logic [15:0] w);
        t_cmd c;
        c = '0;
        c.mode = MODE_VEL;
        c.vehicle_index = 4'(veh);
        c.linear_speed = v;
        c.angular_rate = w;
        c.set_x = $urandom();
        c.set_y = $urandom();
        c.set_heading = 16'($urandom());
        return c;
    endfunction

    function automatic t_cmd set_cmd(int veh, logic [31:0] x, logic [31:0] y,
                                     logic [15:0] h);
        t_cmd c;
        c = '0;
        c.mode = MODE_SET;
        c.vehicle_index = 4'(veh);
        c.set_x = x;
        c.set_y = y;
        c.set_heading = h;
        c.linear_speed = 16'($urandom());
        c.angular_rate = 16'($urandom());
        return c;
    endfunction

    // result checker with random stalls
    always @(posedge i_clk) begin
        t_pose want;
        if (!i_rst_n) begin
            pose_ch.ready <= 1'b0;
        end else begin
            if (pose_ch.valid && pose_ch.ready) begin
                if (pending_poses.size() == 0) begin
                    report_mismatch("unexpected pose",
                                    longint'(pose_ch.data.out_vehicle), 64'sd0);
                end else begin
                    want = pending_poses.pop_front();
                    if (pose_ch.data.out_vehicle !== want.out_vehicle)
                        report_mismatch("out_vehicle",
                                        longint'(pose_ch.data.out_vehicle),
                                        longint'(want.out_vehicle));
                    if (pose_ch.data.pos_x !== want.pos_x)
                        report_mismatch("pos_x", longint'(pose_ch.data.pos_x),
                                        longint'(want.pos_x));
                    if (pose_ch.data.pos_y !== want.pos_y)
                        report_mismatch("pos_y", longint'(pose_ch.data.pos_y),
                                        longint'(want.pos_y));
                    if (pose_ch.data.heading !== want.heading)
                        report_mismatch("heading", longint'(pose_ch.data.heading),
                                        longint'(want.heading));
                end
            end
            pose_ch.ready <= !(idle_on && $urandom_range(99) < 19);
        end
    end

    task automatic test_directed();
        logic [15:0] ext16 [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        send_cmd(vel_cmd(0, 16'h0100, 16'h0000));
        send_cmd(vel_cmd(0, 16'h7FFF, 16'h7FFF));
        send_cmd(vel_cmd(1, 16'h8000, 16'h8000));
        foreach (ext16[k]) send_cmd(set_cmd(2, 32'h0, 32'h0, {ext16[k][15:14], 14'd0}));
        send_cmd(vel_cmd(2, 16'h7FFF, 16'h0000));
        // saturate high then low
        send_cmd(set_cmd(3, 32'h7FFF_FF00, 32'h7FFF_FF00, 16'h2000));
        send_cmd(vel_cmd(3, 16'h7FFF, 16'h0000));
        send_cmd(set_cmd(3, 32'h8000_0100, 32'h8000_0100, 16'hA000));
        send_cmd(vel_cmd(3, 16'h7FFF, 16'h0000));
        // heading wraps; quadrant edges
        send_cmd(set_cmd(4, 32'h0, 32'h0, 16'hFFFF));
        send_cmd(vel_cmd(4, 16'h0200, 16'h0100));
        send_cmd(set_cmd(5, 32'h0, 32'h0, 16'h4000));
        send_cmd(vel_cmd(5, 16'h0100, 16'h0000));
        send_cmd(set_cmd(5, 32'h0, 32'h0, 16'hBFFF));
        send_cmd(vel_cmd(5, 16'h0100, 16'h0000));
        send_cmd(set_cmd(15, 32'hFFFF_FFFF, 32'h1234_5678, 16'h8000));
        send_cmd(vel_cmd(15, 16'hFFFF, 16'hFFFF));
    endtask

    task automatic test_random(int count);
        int veh;
        for (int n = 0; n < count; n++) begin
            veh = $urandom_range(NVEH - 1);
            case ($urandom_range(9))
                0: send_cmd(set_cmd(veh, $urandom(), $urandom(), 16'($urandom())));
                1: send_cmd(vel_cmd(veh, 16'($urandom()), 16'($urandom())));
                default: send_cmd(vel_cmd(veh, 16'($urandom_range(2047) - 1024),
                                          16'($urandom_range(2047) - 1024)));
            endcase
        end
    endtask

    task automatic test_period_settings();
        write_period(16'd0);
        test_random(40);
        write_period(16'hFFFF);
        test_random(60);
        write_period(16'd1);
        test_random(40);
        write_period(16'd3277);
    endtask

    initial begin
        mdl_period = STEP_PERIOD_RESET;
        for (int i = 0; i < NVEH; i++) begin
            mdl_x[i] = '0; mdl_y[i] = '0; mdl_hdg[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(200);
        // hold off until every pose is back
        wait_drained();
        idle_on = 1'b0;
        test_random(100);
        idle_on = 1'b1;
        test_period_settings();
        test_random(140);
        wait_drained();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
design/mvpi_pkg.sv
design/mvpi_cmd_if.sv
design/mvpi_pose_if.sv
design/mvpi_front.sv
design/mvpi_back.sv
design/multi_vehicle_pose_integrator.sv
dv/multi_vehicle_pose_integrator_tb.sv
